### sv/rkw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkw_pkg
// Shared widths, kernel codes and pipeline word types of the kernel weight block.
// ----------------------------------------------------------------------------
package rkw_pkg;

	localparam int TAP_W   = 16;  // tap distance, signed
	localparam int WGT_W   = 16;  // weight, signed Q2.14
	localparam int MAG_W   = 16;  // |tap distance|, 0..32768
	localparam int COEF_W  = 22;  // widest polynomial coefficient, signed
	localparam int ACC_W   = 26;  // Horner accumulator, signed
	localparam int CFG_W   = 32;
	localparam int PADDR_W = 4;

	localparam int ONE_Q14 = 16384;

	localparam logic [2:0] KS_NEAREST = 3'd0;
	localparam logic [2:0] KS_BOX     = 3'd1;
	localparam logic [2:0] KS_LINEAR  = 3'd2;
	localparam logic [2:0] KS_KEYS    = 3'd3;
	localparam logic [2:0] KS_MITCH   = 3'd4;
	localparam logic [2:0] KS_MAGIC   = 3'd5;
	localparam logic [2:0] KS_BSPLINE = 3'd6;

	typedef struct packed {
		logic [2:0]         ksel;
		logic signed [15:0] keys_a;
		logic [14:0]        mit_b;
		logic [14:0]        mit_c;
	} cfg_t;

	typedef struct packed {
		logic [MAG_W-1:0]         t;
		logic signed [ACC_W-1:0]  acc;
		logic signed [COEF_W-1:0] c2;
		logic signed [COEF_W-1:0] c1;
		logic signed [COEF_W-1:0] c0;
		logic                     div6;
	} pipe_t;

endpackage

### sv/rkw_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkw_ifs
// Valid/ready channels for tap distance words and weight words.
// ----------------------------------------------------------------------------
interface rkw_tap_if;
	logic                              valid;
	logic                              ready;
	logic signed [rkw_pkg::TAP_W-1:0]  tap_offset;

	modport source (output valid, output tap_offset, input ready);
	modport sink   (input valid, input tap_offset, output ready);
endinterface

interface rkw_weight_if;
	logic                              valid;
	logic                              ready;
	logic signed [rkw_pkg::WGT_W-1:0]  weight;

	modport source (output valid, output weight, input ready);
	modport sink   (input valid, input weight, output ready);
endinterface

### sv/rkw_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkw_regs
// APB-style register file: kernel select, Keys a, Mitchell B and C.
// ----------------------------------------------------------------------------
module rkw_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rkw_pkg::PADDR_W-1:0]  paddr,
	input  logic [rkw_pkg::CFG_W-1:0]    pwdata,
	output logic [rkw_pkg::CFG_W-1:0]    prdata,
	output logic                         pready,
	output rkw_pkg::cfg_t                cfg
);

	localparam logic [1:0] REG_KSEL   = 2'd0;
	localparam logic [1:0] REG_KEYS_A = 2'd1;
	localparam logic [1:0] REG_MIT_B  = 2'd2;
	localparam logic [1:0] REG_MIT_C  = 2'd3;

	rkw_pkg::cfg_t cfg_q;
	logic [1:0]    idx;
	logic          wr;

	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ksel   <= rkw_pkg::KS_LINEAR;
			cfg_q.keys_a <= -16'sd8192;
			cfg_q.mit_b  <= 15'd5461;
			cfg_q.mit_c  <= 15'd5461;
		end else if (wr) begin
			case (idx)
				REG_KSEL:   cfg_q.ksel   <= pwdata[2:0];
				REG_KEYS_A: cfg_q.keys_a <= pwdata[15:0];
				REG_MIT_B:  cfg_q.mit_b  <= pwdata[14:0];
				REG_MIT_C:  cfg_q.mit_c  <= pwdata[14:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_KSEL:   prdata = rkw_pkg::CFG_W'(cfg_q.ksel);
			REG_KEYS_A: prdata = rkw_pkg::CFG_W'(unsigned'(cfg_q.keys_a));
			REG_MIT_B:  prdata = rkw_pkg::CFG_W'(cfg_q.mit_b);
			REG_MIT_C:  prdata = rkw_pkg::CFG_W'(cfg_q.mit_c);
			default:    prdata = '0;
		endcase
	end

endmodule

### sv/rkw_coef.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkw_coef
// Stage 1: |tap|, support test, per-kernel cubic coefficients.
// ----------------------------------------------------------------------------
module rkw_coef #(
	parameter int POS_FRAC_BITS = 12
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [rkw_pkg::TAP_W-1:0] tap_offset,
	input  rkw_pkg::cfg_t                    cfg,
	output rkw_pkg::pipe_t                   p_s1
);

	localparam int CW = rkw_pkg::COEF_W;
	localparam int RW = rkw_pkg::MAG_W + 2;
	localparam logic [RW-1:0] ONE      = RW'(1) << POS_FRAC_BITS;
	localparam logic [RW-1:0] HALF     = ONE >> 1;
	localparam logic [RW-1:0] TWO      = ONE << 1;
	localparam logic [RW-1:0] ONE_HALF = ONE + HALF;
	localparam int Q = rkw_pkg::ONE_Q14;

	logic signed [rkw_pkg::TAP_W:0] x_ext, x_neg;
	logic [rkw_pkg::MAG_W-1:0]      t;
	logic [RW-1:0]                  tz;
	logic signed [CW-1:0]           a, b, c;
	logic signed [CW-1:0]           c3, c2, c1, c0;
	logic                           div6;

	always_comb begin
		x_ext = {tap_offset[rkw_pkg::TAP_W-1], tap_offset};
		x_neg = -x_ext;
		t     = tap_offset[rkw_pkg::TAP_W-1] ? rkw_pkg::MAG_W'(x_neg)
		                                     : rkw_pkg::MAG_W'(x_ext);
		tz    = RW'(t);
		a     = CW'(cfg.keys_a);
		b     = CW'(cfg.mit_b);
		c     = CW'(cfg.mit_c);
		c3    = '0;
		c2    = '0;
		c1    = '0;
		c0    = '0;
		div6  = 1'b0;
		case (cfg.ksel)
			rkw_pkg::KS_NEAREST: begin
				if (tz <= HALF) c0 = CW'(Q);
			end
			rkw_pkg::KS_BOX: begin
				c0 = CW'(Q);
			end
			rkw_pkg::KS_LINEAR: begin
				if (tz <= ONE) begin
					c1 = CW'(-Q);
					c0 = CW'(Q);
				end
			end
			rkw_pkg::KS_KEYS: begin
				if (tz <= ONE) begin
					c3 = CW'(a + 2 * Q);
					c2 = CW'(-(a + 3 * Q));
					c0 = CW'(Q);
				end else if (tz <= TWO) begin
					c3 = a;
					c2 = CW'(-5 * a);
					c1 = CW'(8 * a);
					c0 = CW'(-4 * a);
				end
			end
			rkw_pkg::KS_MITCH: begin
				div6 = 1'b1;
				if (tz < ONE) begin
					c3 = CW'(12 * Q - 9 * b - 6 * c);
					c2 = CW'(-18 * Q + 12 * b + 6 * c);
					c0 = CW'(6 * Q - 2 * b);
				end else if (tz < TWO) begin
					c3 = CW'(-b - 6 * c);
					c2 = CW'(6 * b + 30 * c);
					c1 = CW'(-12 * b - 48 * c);
					c0 = CW'(8 * b + 24 * c);
				end
			end
			rkw_pkg::KS_MAGIC: begin
				if (tz < HALF) begin
					c2 = CW'(-Q);
					c0 = CW'(12288);
				end else if (tz < ONE_HALF) begin
					c2 = CW'(8192);
					c1 = CW'(-24576);
					c0 = CW'(18432);
				end
			end
			rkw_pkg::KS_BSPLINE: begin
				div6 = 1'b1;
				if (tz <= ONE) begin
					c3 = CW'(3 * Q);
					c2 = CW'(-6 * Q);
					c0 = CW'(4 * Q);
				end else if (tz <= TWO) begin
					c3 = CW'(-Q);
					c2 = CW'(6 * Q);
					c1 = CW'(-12 * Q);
					c0 = CW'(8 * Q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1.t    <= t;
			p_s1.acc  <= rkw_pkg::ACC_W'(c3);
			p_s1.c2   <= c2;
			p_s1.c1   <= c1;
			p_s1.c0   <= c0;
			p_s1.div6 <= div6;
		end
	end

endmodule

### sv/rkw_horner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkw_horner
// One Horner step: acc = round(acc * t >> F) + next coefficient, registered.
// ----------------------------------------------------------------------------
module rkw_horner #(
	parameter int POS_FRAC_BITS = 12,
	parameter int STEP          = 0
) (
	input  logic           clk,
	input  logic           en,
	input  rkw_pkg::pipe_t p_in,
	output rkw_pkg::pipe_t p_out
);

	localparam int AW = rkw_pkg::ACC_W;
	localparam int PW = rkw_pkg::ACC_W + rkw_pkg::MAG_W + 1;
	localparam logic signed [PW-1:0] RND = PW'(1) << (POS_FRAC_BITS - 1);

	logic signed [PW-1:0]              prod, shifted;
	logic signed [rkw_pkg::COEF_W-1:0] cadd;
	rkw_pkg::pipe_t                    nxt;

	always_comb begin
		prod    = p_in.acc * $signed({1'b0, p_in.t});
		shifted = (prod + RND) >>> POS_FRAC_BITS;  // round half up
		cadd    = (STEP == 0) ? p_in.c2 : ((STEP == 1) ? p_in.c1 : p_in.c0);
		nxt     = p_in;
		nxt.acc = AW'(shifted) + AW'(cadd);
	end

	always_ff @(posedge clk) begin
		if (en) p_out <= nxt;
	end

endmodule

### sv/rkw_div6.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkw_div6
// Stages 5-6: optional floor((v + 3) / 6) by reciprocal, then saturation.
// ----------------------------------------------------------------------------
module rkw_div6 (
	input  logic                             clk,
	input  logic                             en5,
	input  logic                             en6,
	input  rkw_pkg::pipe_t                   p_in,
	output logic signed [rkw_pkg::WGT_W-1:0] weight_s6
);

	localparam int AW   = rkw_pkg::ACC_W;
	localparam int UW   = AW + 2;
	localparam int HW   = AW;
	localparam int MW   = 32;
	localparam int PW   = HW + MW;
	localparam int OFFS = 1 << (AW - 2);      // bias / 6, makes the dividend positive
	localparam int BIAS = 6 * OFFS + 3;
	localparam logic [MW-1:0] RECIP3 = 32'd1431655765;  // floor(2^32 / 3)
	localparam logic signed [HW:0] WMAX = (HW + 1)'(32767);
	localparam logic signed [HW:0] WMIN = -(HW + 1)'(32768);

	logic signed [UW-1:0] u;
	logic [HW-1:0]        h;
	logic [PW-1:0]        prod;

	logic [HW-1:0]        h_s5, q0_s5;
	logic signed [AW-1:0] acc_s5;
	logic                 div6_s5;

	logic [HW+1:0]        r;
	logic [HW-1:0]        q;
	logic signed [HW:0]   wq, v;
	logic signed [rkw_pkg::WGT_W-1:0] sat;

	always_comb begin
		u    = UW'(p_in.acc) + UW'(BIAS);
		h    = u[HW:1];  // floor(u / 2), then divide by 3
		prod = PW'(h) * PW'(RECIP3);
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			h_s5    <= h;
			q0_s5   <= prod[PW-1:MW];
			acc_s5  <= p_in.acc;
			div6_s5 <= p_in.div6;
		end
	end

	// quotient estimate is exact or one short
	always_comb begin
		r  = {2'b00, h_s5} - ({2'b00, q0_s5} + {1'b0, q0_s5, 1'b0});
		q  = q0_s5 + HW'(r >= (HW + 2)'(3));
		wq = $signed({1'b0, q}) - (HW + 1)'(OFFS);
		v  = div6_s5 ? wq : (HW + 1)'(acc_s5);
		if (v > WMAX)
			sat = 16'sh7fff;
		else if (v < WMIN)
			sat = -16'sh8000;
		else
			sat = rkw_pkg::WGT_W'(v);
	end

	always_ff @(posedge clk) begin
		if (en6) weight_s6 <= sat;
	end

endmodule

### sv/resample_kernel_weight.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resample_kernel_weight
// Interpolation weight of a selectable resampling kernel for one tap distance.
// ----------------------------------------------------------------------------
// Usage:
//  - taps: valid/ready channel, one word = signed tap distance (POS_FRAC_BITS
//    fraction bits). weights: valid/ready channel, one word = signed Q2.14
//    weight, saturated. One weight word per tap word, in order.
//  - APB-style port: 0x0 kernel select, 0x4 Keys a, 0x8 Mitchell B,
//    0xC Mitchell C. pready is tied high. Write registers only while no word
//    is in flight.
//  - Six register stages from tap accept to weight valid: coefficient
//    select, three Horner steps, reciprocal multiply, fixup and saturate.
//  - Throughput: one word per cycle while the weight sink is ready; each
//    Horner step owns its multiplier.
//  - Reset clears all stage valid bits and loads the register defaults
//    (linear kernel, a = -0.5, B = C = 1/3).
//  - When the weight sink stalls, words close up into empty stages; taps.ready
//    drops only once all six stages hold words. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module resample_kernel_weight #(
	parameter int POS_FRAC_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	rkw_tap_if.sink                      taps,
	rkw_weight_if.source                 weights,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rkw_pkg::PADDR_W-1:0]  paddr,
	input  logic [rkw_pkg::CFG_W-1:0]    pwdata,
	output logic [rkw_pkg::CFG_W-1:0]    prdata,
	output logic                         pready
);

	rkw_pkg::cfg_t  cfg;
	rkw_pkg::pipe_t p_s1, p_s2, p_s3, p_s4;
	logic signed [rkw_pkg::WGT_W-1:0] weight_s6;

	// stage valid bits and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	// a stage loads when it is empty or its content moves on
	assign en6 = !v_s6 || weights.ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign taps.ready     = en1;
	assign weights.valid  = v_s6;
	assign weights.weight = weight_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= taps.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	rkw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// |t|, support window and coefficients c3..c0
	rkw_coef #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_coef (
		.clk        (clk),
		.en         (en1),
		.tap_offset (taps.tap_offset),
		.cfg        (cfg),
		.p_s1       (p_s1)
	);

	// Horner: acc = c3 -> +c2 -> +c1 -> +c0
	rkw_horner #(.POS_FRAC_BITS(POS_FRAC_BITS), .STEP(0)) u_h2 (
		.clk   (clk),
		.en    (en2),
		.p_in  (p_s1),
		.p_out (p_s2)
	);

	rkw_horner #(.POS_FRAC_BITS(POS_FRAC_BITS), .STEP(1)) u_h3 (
		.clk   (clk),
		.en    (en3),
		.p_in  (p_s2),
		.p_out (p_s3)
	);

	rkw_horner #(.POS_FRAC_BITS(POS_FRAC_BITS), .STEP(2)) u_h4 (
		.clk   (clk),
		.en    (en4),
		.p_in  (p_s3),
		.p_out (p_s4)
	);

	// Mitchell and B-spline carry 6x coefficients; divide here, then clamp
	rkw_div6 u_div6 (
		.clk       (clk),
		.en5       (en5),
		.en6       (en6),
		.p_in      (p_s4),
		.weight_s6 (weight_s6)
	);

	// empty output stage frees the whole chain
	a_empty_tail_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s6 |-> taps.ready)
		else $error("taps.ready low with output stage empty");

	a_full_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !weights.ready)
		|-> !taps.ready)
		else $error("tap word taken into a full stalled pipeline");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(taps.valid && taps.ready) |=> v_s1)
		else $error("accepted tap word missing from stage 1");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		(weights.valid && weights.ready && !v_s5) |=> !weights.valid)
		else $error("weight word appeared without a source word");

endmodule
